// ----- rtl/core/drum_step_sequencer_assert.svh -----
// Assertion macros for the drum step sequencer.
// Each macro uses the clk and rst_n of the module that includes this file.
`ifndef DRUM_STEP_SEQUENCER_ASSERT_SVH
`define DRUM_STEP_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dss_pkg.sv -----
// Shared types and constants for the drum step sequencer.
// No dependencies.
package dss_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_TOGGLE     = 3'd1,
        OP_TRACK_STATE = 3'd2,
        OP_GLOBAL_STATE = 3'd3,
        OP_SET_POS    = 3'd4
    } op_t;

    localparam logic [1:0] ST_STOP   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_TOGGLE = 2'd2;

    localparam logic CFG_BPM      = 1'b0;
    localparam logic CFG_HIT_TIME = 1'b1;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [9:0]  BPM_RESET     = 10'd120;
    localparam logic [15:0] HIT_RESET     = 16'd20;
    localparam logic [15:0] INTERVAL_RESET = 16'd500;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 16;

endpackage

// ----- rtl/core/drum_step_sequencer.sv -----
// Drum step sequencer: pattern storage, beat and release countdowns, transport control.
// Depends on dss_pkg and drum_step_sequencer_assert.svh.
//
// Latency: one result per item, valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the result side takes results and the divider is idle.
// A tempo write starts a restoring divider (60000 / tempo); no item is taken
// until it finishes. Configuration writes are taken in every cycle.
// Reset leaves the state after the start beat: position 1, running, all tracks enabled,
// beat countdown 500 ms, release countdown 20 ms, patterns and actuators clear.
module drum_step_sequencer
    import dss_pkg::*;
#(
    parameter int STEP_COUNT  = 16,
    parameter int TRACK_COUNT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: track_index[1:0], step_index[5:2], state_code[7:6],
    // new_position[11:8]; upper bits zero.
    input  logic [15:0] s_axis_tdata,
    // Fields from bit 0: operation[2:0].
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: actuator_drive[3:0], step_position[7:4], running[8],
    // track_enable_mask[12:9], note_bit[13], beat_fired[14]; bit 15 zero.
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int POS_W = (STEP_COUNT > 2) ? $clog2(STEP_COUNT) : 1;

    typedef logic [STEP_COUNT-1:0]  row_t;
    typedef logic [TRACK_COUNT-1:0] trk_vec_t;

    // Storage
    row_t             pattern_reg [TRACK_COUNT];
    row_t             pattern_next [TRACK_COUNT];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             run_flag_reg, run_flag_next;
    trk_vec_t         enables_reg, enables_next;
    logic [15:0]      beat_cnt_reg, beat_cnt_next;
    logic             beat_armed_reg, beat_armed_next;
    logic [15:0]      rel_cnt_reg, rel_cnt_next;
    logic             rel_armed_reg, rel_armed_next;
    trk_vec_t         act_reg, act_next;
    logic [15:0]      hit_time_reg;

    // Divider; the quotient register is the beat interval once the divider is idle.
    logic [15:0] div_quot_reg;
    logic [9:0]  div_rem_reg;
    logic [9:0]  div_divisor_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy;
    logic [10:0] div_trial;

    // Result register
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    // Decoded request
    logic        in_accept;
    op_t         op;
    logic [1:0]  track_index;
    logic [3:0]  step_index;
    logic [1:0]  state_code;
    logic [3:0]  new_position;
    row_t        step_mask;
    trk_vec_t    trk_mask;
    logic        fire;
    logic        note;

    assign track_index  = s_axis_tdata[1:0];
    assign step_index   = s_axis_tdata[5:2];
    assign state_code   = s_axis_tdata[7:6];
    assign new_position = s_axis_tdata[11:8];
    assign op           = op_t'(s_axis_tuser);

    // Out-of-range indexes shift the one-hot bit off the end and address nothing.
    assign step_mask = row_t'(1) << step_index;
    assign trk_mask  = trk_vec_t'(1) << track_index;

    assign div_busy      = (div_cnt_reg != 5'd0);
    assign s_axis_tready = !div_busy && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    function automatic logic [POS_W-1:0] load_pos(input logic [3:0] v);
        logic [7:0] r;
        r = 8'(v);
        for (int i = 0; i < 8; i++) begin
            if (r >= 8'(STEP_COUNT))
            begin
                r = r - 8'(STEP_COUNT);
            end
        end
        return POS_W'(r);
    endfunction

    // The remainder stays below the divisor, so ten bits hold it.
    assign div_trial = {div_rem_reg, div_quot_reg[15]};

    always_comb
    begin
        for (int t = 0; t < TRACK_COUNT; t++) begin
            pattern_next[t] = pattern_reg[t];
        end
        pos_next        = pos_reg;
        run_flag_next   = run_flag_reg;
        enables_next    = enables_reg;
        beat_cnt_next   = beat_cnt_reg;
        beat_armed_next = beat_armed_reg;
        rel_cnt_next    = rel_cnt_reg;
        rel_armed_next  = rel_armed_reg;
        act_next        = act_reg;
        fire            = 1'b0;
        note            = 1'b0;

        case (op)
            OP_TICK:
            begin
                // Release is handled before the beat so a beat on the same tick re-engages.
                if (rel_armed_reg)
                begin
                    if (rel_cnt_reg <= 16'd1)
                    begin
                        rel_armed_next = 1'b0;
                        rel_cnt_next   = 16'd0;
                        act_next       = '0;
                    end
                    else
                    begin
                        rel_cnt_next = rel_cnt_reg - 16'd1;
                    end
                end
                if (beat_armed_reg)
                begin
                    if (beat_cnt_reg <= 16'd1)
                    begin
                        fire = 1'b1;
                    end
                    else
                    begin
                        beat_cnt_next = beat_cnt_reg - 16'd1;
                    end
                end
            end
            OP_TOGGLE:
            begin
                for (int t = 0; t < TRACK_COUNT; t++) begin
                    if (trk_mask[t])
                    begin
                        pattern_next[t] = pattern_reg[t] ^ step_mask;
                    end
                end
            end
            OP_TRACK_STATE:
            begin
                case (state_code)
                    ST_STOP:   enables_next = enables_reg & ~trk_mask;
                    ST_RUN:    enables_next = enables_reg | trk_mask;
                    ST_TOGGLE: enables_next = enables_reg ^ trk_mask;
                    default:   enables_next = enables_reg;
                endcase
            end
            OP_GLOBAL_STATE:
            begin
                if (state_code == ST_STOP || (state_code == ST_TOGGLE && run_flag_reg))
                begin
                    beat_armed_next = 1'b0;
                    pos_next        = '0;
                    run_flag_next   = 1'b0;
                    enables_next    = '0;
                end
                else if (state_code == ST_RUN || state_code == ST_TOGGLE)
                begin
                    // The start beat uses the enables from before the run.
                    fire = 1'b1;
                end
            end
            OP_SET_POS:
            begin
                pos_next = load_pos(new_position);
            end
            default:
            begin
            end
        endcase

        if (fire)
        begin
            beat_cnt_next   = div_quot_reg;
            beat_armed_next = 1'b1;
            for (int t = 0; t < TRACK_COUNT; t++) begin
                if (pattern_reg[t][pos_reg] && enables_reg[t])
                begin
                    act_next[t] = 1'b1;
                end
            end
            rel_cnt_next   = hit_time_reg;
            rel_armed_next = 1'b1;
            pos_next = (pos_reg == POS_W'(STEP_COUNT - 1)) ? '0 : pos_reg + POS_W'(1);
        end
        if (op == OP_GLOBAL_STATE && fire)
        begin
            run_flag_next = 1'b1;
            enables_next  = '1;
        end

        for (int t = 0; t < TRACK_COUNT; t++) begin
            if (trk_mask[t] && ((pattern_next[t] & step_mask) != '0))
            begin
                note = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TRACK_COUNT; t++) begin
                pattern_reg[t] <= '0;
            end
            pos_reg         <= POS_W'(1);
            run_flag_reg    <= 1'b1;
            enables_reg     <= '1;
            beat_cnt_reg    <= INTERVAL_RESET;
            beat_armed_reg  <= 1'b1;
            rel_cnt_reg     <= HIT_RESET;
            rel_armed_reg   <= 1'b1;
            act_reg         <= '0;
            hit_time_reg    <= HIT_RESET;
            div_quot_reg    <= INTERVAL_RESET;
            div_rem_reg     <= '0;
            div_divisor_reg <= BPM_RESET;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                for (int t = 0; t < TRACK_COUNT; t++) begin
                    pattern_reg[t] <= pattern_next[t];
                end
                pos_reg        <= pos_next;
                run_flag_reg   <= run_flag_next;
                enables_reg    <= enables_next;
                beat_cnt_reg   <= beat_cnt_next;
                beat_armed_reg <= beat_armed_next;
                rel_cnt_reg    <= rel_cnt_next;
                rel_armed_reg  <= rel_armed_next;
                act_reg        <= act_next;
            end

            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_index == CFG_HIT_TIME)
            begin
                hit_time_reg <= cfg_data;
            end

            if (cfg_valid && cfg_index == CFG_BPM)
            begin
                // A zero tempo divides like a tempo of one.
                div_divisor_reg <= (cfg_data[9:0] == 10'd0) ? 10'd1 : cfg_data[9:0];
                div_quot_reg    <= MS_PER_MINUTE;
                div_rem_reg     <= '0;
                div_cnt_reg     <= 5'(DIV_STEPS);
            end
            else if (div_busy)
            begin
                if (div_trial >= {1'b0, div_divisor_reg})
                begin
                    div_rem_reg  <= 10'(div_trial - {1'b0, div_divisor_reg});
                    div_quot_reg <= {div_quot_reg[14:0], 1'b1};
                end
                else
                begin
                    div_rem_reg  <= div_trial[9:0];
                    div_quot_reg <= {div_quot_reg[14:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= {1'b0, fire, note, 4'(enables_next), run_flag_next,
                             4'(pos_next), 4'(act_next)};
        end
    end

`include "drum_step_sequencer_assert.svh"

    `DSS_ASSERT_IMP(a_no_accept_in_divide, s_axis_tready, !div_busy, "request during divide")
    `DSS_ASSERT_NXT(a_beat_rearms, in_accept && fire, beat_armed_reg && rel_armed_reg, "no re-arm")
    `DSS_ASSERT_IMP(a_stopped_disarmed, !run_flag_reg, !beat_armed_reg, "armed while stopped")
    `DSS_ASSERT_IMP(a_release_clears, !rel_armed_reg, act_reg == '0, "engaged when released")

endmodule

// ----- verif/dss_checker.sv -----
// Scoreboard for the drum step sequencer: watches the command, result and register channels,
// keeps its own copy of the pattern, transport and countdown state, and compares each result.
// Depends on dss_pkg.
module dss_checker
    import dss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          results_due,
    output int          results_checked,
    output int          beats_fired,
    output int          engaged_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS  = 16;
    localparam int TRACKS = 4;

    // Same layout as m_axis_tdata, highest field first.
    typedef struct packed {
        logic       pad;
        logic       beat;
        logic       note;
        logic [3:0] enables;
        logic       running;
        logic [3:0] position;
        logic [3:0] drive;
    } seq_result_t;

    seq_result_t predicted_q[$];

    logic [15:0] pattern [TRACKS];
    logic [3:0]  position;
    logic        running;
    logic [3:0]  enables;
    logic [15:0] beat_left;
    logic        beat_armed;
    logic [15:0] release_left;
    logic        release_armed;
    logic [3:0]  drive;
    logic [9:0]  tempo;
    logic [15:0] hit_ms;

    int n_bad;
    int n_checked;
    int n_beats;
    int n_engaged;

    function automatic logic [15:0] beat_period(input logic [9:0] bpm);
        int divisor;
        // A tempo of zero plays as the slowest tempo.
        divisor = (bpm == 10'd0) ? 1 : int'(bpm);
        return 16'(int'(MS_PER_MINUTE) / divisor);
    endfunction

    task automatic play_beat();
        beat_left = beat_period(tempo);
        beat_armed = 1'b1;
        for (int t = 0; t < TRACKS; t++)
            if (pattern[t][position] && enables[t])
                drive[t] = 1'b1;
        release_left = hit_ms;
        release_armed = 1'b1;
        position = 4'((int'(position) + 1) % STEPS);
    endtask

    task automatic start_transport();
        // The beat uses the enables as they were before the start.
        play_beat();
        running = 1'b1;
        enables = '1;
    endtask

    task automatic stop_transport();
        beat_armed = 1'b0;
        position = '0;
        running = 1'b0;
        enables = '0;
    endtask

    task automatic clear_model();
        tempo = BPM_RESET;
        hit_ms = HIT_RESET;
        for (int t = 0; t < TRACKS; t++)
            pattern[t] = '0;
        position = '0;
        running = 1'b0;
        enables = '0;
        beat_left = '0;
        beat_armed = 1'b0;
        release_left = '0;
        release_armed = 1'b0;
        drive = '0;
        start_transport();
    endtask

    task automatic predict_command(input logic [2:0] op, input logic [15:0] data,
                                   output seq_result_t r);
        logic [1:0] trk;
        logic [3:0] stp;
        logic [1:0] code;
        logic [3:0] npos;
        logic       fired;
        trk = data[1:0];
        stp = data[5:2];
        code = data[7:6];
        npos = data[11:8];
        fired = 1'b0;
        case (op)
            OP_TICK:
            begin
                // Release is handled before the beat, so a beat on this tick re-engages.
                if (release_armed)
                begin
                    if (release_left <= 16'd1)
                    begin
                        release_armed = 1'b0;
                        release_left = '0;
                        drive = '0;
                    end
                    else
                        release_left = release_left - 16'd1;
                end
                if (beat_armed)
                begin
                    if (beat_left <= 16'd1)
                    begin
                        play_beat();
                        fired = 1'b1;
                    end
                    else
                        beat_left = beat_left - 16'd1;
                end
            end
            OP_TOGGLE:
                pattern[trk][stp] = !pattern[trk][stp];
            OP_TRACK_STATE:
            begin
                if (code == ST_STOP)
                    enables[trk] = 1'b0;
                else if (code == ST_RUN)
                    enables[trk] = 1'b1;
                else if (code == ST_TOGGLE)
                    enables[trk] = !enables[trk];
            end
            OP_GLOBAL_STATE:
            begin
                if (code == ST_STOP || (code == ST_TOGGLE && running))
                    stop_transport();
                else if (code == ST_RUN || code == ST_TOGGLE)
                begin
                    start_transport();
                    fired = 1'b1;
                end
            end
            OP_SET_POS:
                position = 4'(int'(npos) % STEPS);
            default:
                ;
        endcase
        r.pad = 1'b0;
        r.beat = fired;
        r.note = pattern[trk][stp];
        r.enables = enables;
        r.running = running;
        r.position = position;
        r.drive = drive;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seq_result_t want;
        seq_result_t got;
        if (!rst_n)
        begin
            clear_model();
            predicted_q.delete();
            n_bad = 0;
            n_checked = 0;
            n_beats = 0;
            n_engaged = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BPM)
                    tempo = cfg_data[9:0];
                else
                    hit_ms = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_command(s_axis_tuser, s_axis_tdata, want);
                if (want.beat)
                begin
                    n_beats++;
                    if (want.drive != '0)
                        n_engaged++;
                end
                predicted_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = seq_result_t'(m_axis_tdata);
                if (predicted_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result %h with no command outstanding",
                                 m_axis_tdata);
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (got !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $display("result %0d mismatch (expected/actual):", n_checked);
                            $display("  drive %h/%h position %0d/%0d running %b/%b",
                                     want.drive, got.drive, want.position, got.position,
                                     want.running, got.running);
                            $display("  enables %h/%h note %b/%b beat %b/%b pad %b/%b",
                                     want.enables, got.enables, want.note, got.note,
                                     want.beat, got.beat, want.pad, got.pad);
                        end
                    end
                    n_checked++;
                end
            end
        end
        mismatch_count <= n_bad;
        results_due <= predicted_q.size();
        results_checked <= n_checked;
        beats_fired <= n_beats;
        engaged_beats <= n_engaged;
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the drum step sequencer testbench: clock, reset, command and register stimulus,
// result-side back-pressure and the verdict. Depends on dss_pkg, dss_checker and the block.
module testbench;
    import dss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [1:0] ST_SPARE       = 2'd3;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int mismatch_count;
    int results_due;
    int results_checked;
    int beats_fired;
    int engaged_beats;

    int items_sent = 0;
    int settings_used = 1;
    int cycle_count = 0;
    int recv_hold = 0;
    bit recv_bursty = 1'b1;
    bit send_bursty = 1'b1;
    bit quiet = 1'b0;

    drum_step_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dss_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_due     (results_due),
        .results_checked (results_checked),
        .beats_fired     (beats_fired),
        .engaged_beats   (engaged_beats)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, with calm stretches in between.
    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold = recv_hold - 1;
            m_axis_tready <= (recv_hold == 0);
        end
        else if (!quiet && recv_bursty && $urandom_range(0, 4) == 0)
        begin
            recv_hold = $urandom_range(1, 12);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
        if ($urandom_range(0, 39) == 0)
            recv_bursty = !recv_bursty;
    end

    task automatic send_cmd(input logic [2:0] op, input logic [1:0] trk, input logic [3:0] stp,
                            input logic [1:0] code, input logic [3:0] npos);
        int gap;
        if (!quiet && send_bursty && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, npos, code, stp, trk};
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if ($urandom_range(0, 29) == 0)
            send_bursty = !send_bursty;
    endtask

    task automatic send_any(input logic [2:0] op);
        send_cmd(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    endtask

    task automatic send_global();
        int w;
        logic [1:0] code;
        w = $urandom_range(0, 9);
        if (w < 2)
            code = ST_STOP;
        else if (w < 6)
            code = ST_RUN;
        else if (w < 9)
            code = ST_TOGGLE;
        else
            code = ST_SPARE;
        send_cmd(OP_GLOBAL_STATE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), code,
                 4'($urandom_range(0, 15)));
    endtask

    task automatic send_edit();
        int w;
        w = $urandom_range(0, 9);
        if (w < 4)
            send_any(OP_TOGGLE);
        else if (w < 6)
            send_any(OP_TRACK_STATE);
        else if (w < 8)
            send_any(OP_SET_POS);
        else if (w < 9)
            send_any(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
        else
            send_any(OP_TICK);
    endtask

    // Mostly long runs of millisecond ticks so that beats and releases expire,
    // sprinkled with pattern edits and the occasional transport command.
    task automatic play_random(input int budget);
        int first;
        int pick;
        int burst;
        first = items_sent;
        while (items_sent - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                burst = $urandom_range(20, 90);
                repeat (burst)
                begin
                    if ($urandom_range(0, 14) == 0)
                        send_edit();
                    else
                        send_any(OP_TICK);
                end
            end
            else if (pick < 80)
                send_edit();
            else
                send_global();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_settings(input logic [9:0] tempo, input logic [15:0] hit_ms);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HIT_TIME;
        cfg_data <= hit_ms;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_BPM;
        cfg_data <= {6'b0, tempo};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [9:0]  tempo;
        logic [15:0] hit_ms;
        int          budget;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_TICK;
        m_axis_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BPM;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands at the reset tempo: pattern edges, readback through
        // the spare operations, every track state code and the run, toggle and spare transport codes.
        send_cmd(OP_TICK, 2'd0, 4'd0, ST_STOP, 4'd0);
        send_cmd(OP_TOGGLE, 2'd0, 4'd0, ST_STOP, 4'd0);
        send_cmd(OP_TOGGLE, 2'd3, 4'd15, ST_SPARE, 4'd15);
        send_cmd(OP_TOGGLE, 2'd1, 4'd1, ST_RUN, 4'd1);
        send_cmd(OP_TOGGLE, 2'd2, 4'd2, ST_TOGGLE, 4'd2);
        send_cmd(OP_SPARE_FIRST, 2'd3, 4'd15, ST_SPARE, 4'd15);
        send_cmd(OP_SPARE_LAST, 2'd0, 4'd15, ST_STOP, 4'd0);
        send_cmd(OP_SPARE_MID, 2'd1, 4'd1, ST_RUN, 4'd7);
        send_cmd(OP_TRACK_STATE, 2'd3, 4'd15, ST_STOP, 4'd0);
        send_cmd(OP_TRACK_STATE, 2'd3, 4'd0, ST_RUN, 4'd0);
        send_cmd(OP_TRACK_STATE, 2'd0, 4'd0, ST_TOGGLE, 4'd0);
        send_cmd(OP_TRACK_STATE, 2'd1, 4'd1, ST_SPARE, 4'd0);
        send_cmd(OP_SET_POS, 2'd0, 4'd0, ST_STOP, 4'd15);
        send_cmd(OP_SET_POS, 2'd3, 4'd15, ST_SPARE, 4'd0);
        send_cmd(OP_SET_POS, 2'd1, 4'd1, ST_STOP, 4'd1);
        send_cmd(OP_GLOBAL_STATE, 2'd1, 4'd1, ST_RUN, 4'd0);
        send_cmd(OP_GLOBAL_STATE, 2'd0, 4'd0, ST_TOGGLE, 4'd0);
        send_cmd(OP_GLOBAL_STATE, 2'd0, 4'd0, ST_SPARE, 4'd0);
        send_cmd(OP_GLOBAL_STATE, 2'd2, 4'd2, ST_RUN, 4'd0);
        send_cmd(OP_GLOBAL_STATE, 2'd0, 4'd0, ST_TOGGLE, 4'd0);
        send_cmd(OP_GLOBAL_STATE, 2'd1, 4'd1, ST_TOGGLE, 4'd0);
        send_cmd(OP_TOGGLE, 2'd0, 4'd0, ST_STOP, 4'd0);
        send_cmd(OP_TICK, 2'd3, 4'd15, ST_SPARE, 4'd15);
        send_cmd(OP_TICK, 2'd2, 4'd2, ST_TOGGLE, 4'd2);
        play_random(120);

        for (int p = 1; p <= 5; p++)
        begin
            drain();
            case (p)
                1:
                begin
                    tempo = 10'd1000;
                    hit_ms = 16'd1;
                    budget = 200;
                end
                2:
                begin
                    tempo = 10'd1;
                    hit_ms = 16'd65535;
                    budget = 60;
                end
                3:
                begin
                    tempo = 10'd600;
                    hit_ms = 16'd7;
                    budget = 150;
                end
                4:
                begin
                    // Zero tempo must behave as the slowest one.
                    tempo = 10'd0;
                    hit_ms = 16'd3;
                    budget = 60;
                end
                default:
                begin
                    tempo = 10'($urandom_range(700, 1000));
                    hit_ms = 16'($urandom_range(1, 40));
                    budget = 160;
                    quiet = 1'b1;
                end
            endcase
            load_settings(tempo, hit_ms);
            play_random(budget);
        end

        drain();
        $display("Sent %0d commands over %0d register settings; %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("%0d beats evaluated, %0d of them engaging at least one actuator.",
                 beats_fired, engaged_beats);
        if (mismatch_count == 0 && results_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- drum_step_sequencer.f -----
+incdir+rtl/core
rtl/core/dss_pkg.sv
rtl/core/drum_step_sequencer.sv
verif/dss_checker.sv
verif/testbench.sv
